[rtl/core/ffc_pkg.sv]
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types and constants of the fixed-length frame checker: frame layout,
// status codes, register map and the per-word result record.
// ----------------------------------------------------------------------------
package ffc_pkg;

    // frame layout
    localparam int HEADER_BYTES      = 21;
    localparam int HDR_FIELD_BYTES   = 20;   // header bytes that carry fields
    localparam int PAYLOAD_BYTES_DEF = 128;
    localparam int OFFSET_W          = 13;

    // field byte positions inside the header, little-endian
    localparam int OFF_PREAMBLE = 0;
    localparam int OFF_SEQ      = 2;
    localparam int OFF_SECONDS  = 6;
    localparam int OFF_MICROS   = 10;
    localparam int OFF_LENGTH   = 14;
    localparam int OFF_TYPE     = 18;

    // frame status codes
    localparam logic [1:0] ST_GOOD         = 2'd0;
    localparam logic [1:0] ST_BAD_PREAMBLE = 2'd1;
    localparam logic [1:0] ST_BAD_SUM      = 2'd2;

    // register map
    localparam int          APB_ADDR_W      = 3;
    localparam logic        REG_IDX_PREAMBLE = 1'b0;  // paddr[2]
    localparam logic [15:0] PREAMBLE_RESET   = 16'h20F7;

    // output word packing
    localparam int TDATA_W = 168;

    // one result word
    typedef struct packed {
        logic [7:0]          data_byte;
        logic [OFFSET_W-1:0] byte_offset;
        logic                in_payload;
        logic                frame_end;
        logic [1:0]          frame_status;
        logic [31:0]         seq_number;
        logic [31:0]         stamp_seconds;
        logic [31:0]         stamp_micros;
        logic [31:0]         payload_length;
        logic [15:0]         payload_type;
    } t_result;

endpackage

[rtl/core/ffc_in_reg.sv]
// ----------------------------------------------------------------------------
// ffc_in_reg
// Input register stage: holds one received byte until the frame core takes it.
// ----------------------------------------------------------------------------
module ffc_in_reg
    import ffc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // free when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // byte holding register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[rtl/core/ffc_frame_core.sv]
// ----------------------------------------------------------------------------
// ffc_frame_core
// Frame state: byte offset counter, modulo-256 running sum and header byte
// capture; forms the result word for the byte at the input register.
// ----------------------------------------------------------------------------
module ffc_frame_core
    import ffc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_expected_preamble,
    output t_result     o_result
);

    localparam logic [OFFSET_W-1:0] FRAME_LAST =
        OFFSET_W'(HEADER_BYTES + PAYLOAD_BYTES - 1);

    logic [OFFSET_W-1:0] r_offset;
    logic [OFFSET_W-1:0] n_offset;
    logic [7:0]          r_sum;
    logic [7:0]          n_sum;
    logic [7:0]          r_hdr [HDR_FIELD_BYTES];

    logic [OFFSET_W-1:0] w_off;
    logic                w_last;
    logic [15:0]         w_preamble;
    logic [1:0]          w_status;

    // offset, sum and next count
    always_comb begin
        w_off    = (r_offset > FRAME_LAST) ? '0 : r_offset;
        w_last   = (w_off == FRAME_LAST);
        n_sum    = (w_off == '0) ? i_byte : 8'(r_sum + i_byte);
        n_offset = w_last ? '0 : OFFSET_W'(w_off + 1'b1);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_sum    <= '0;
            for (int i = 0; i < HDR_FIELD_BYTES; i++) begin
                r_hdr[i] <= '0;
            end
        end else if (i_fire) begin
            r_offset <= n_offset;
            r_sum    <= n_sum;
            for (int i = 0; i < HDR_FIELD_BYTES; i++) begin
                if (w_off == OFFSET_W'(i)) begin
                    r_hdr[i] <= i_byte;
                end
            end
        end
    end

    assign w_preamble = {r_hdr[OFF_PREAMBLE+1], r_hdr[OFF_PREAMBLE]};

    // status: preamble checked before the sum
    always_comb begin
        if (w_preamble != i_expected_preamble) begin
            w_status = ST_BAD_PREAMBLE;
        end else if (n_sum != 8'd0) begin
            w_status = ST_BAD_SUM;
        end else begin
            w_status = ST_GOOD;
        end
    end

    // result word; header fields only on the last byte
    always_comb begin
        o_result             = '0;
        o_result.data_byte   = i_byte;
        o_result.byte_offset = w_off;
        o_result.in_payload  = (w_off >= OFFSET_W'(HEADER_BYTES));
        o_result.frame_end   = w_last;
        if (w_last) begin
            o_result.frame_status   = w_status;
            o_result.seq_number     = {r_hdr[OFF_SEQ+3], r_hdr[OFF_SEQ+2],
                                       r_hdr[OFF_SEQ+1], r_hdr[OFF_SEQ]};
            o_result.stamp_seconds  = {r_hdr[OFF_SECONDS+3], r_hdr[OFF_SECONDS+2],
                                       r_hdr[OFF_SECONDS+1], r_hdr[OFF_SECONDS]};
            o_result.stamp_micros   = {r_hdr[OFF_MICROS+3], r_hdr[OFF_MICROS+2],
                                       r_hdr[OFF_MICROS+1], r_hdr[OFF_MICROS]};
            o_result.payload_length = {r_hdr[OFF_LENGTH+3], r_hdr[OFF_LENGTH+2],
                                       r_hdr[OFF_LENGTH+1], r_hdr[OFF_LENGTH]};
            o_result.payload_type   = {r_hdr[OFF_TYPE+1], r_hdr[OFF_TYPE]};
        end
    end

endmodule

[rtl/core/ffc_out_reg.sv]
// ----------------------------------------------------------------------------
// ffc_out_reg
// Result register stage: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module ffc_out_reg
    import ffc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // load when empty or when the held word leaves this cycle
    assign o_advance = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    // result holding register
    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/core/fixed_frame_checker.sv]
// ----------------------------------------------------------------------------
// fixed_frame_checker
// Fixed-length frame deframer with additive checksum check.
// ----------------------------------------------------------------------------
// The stream is cut into back-to-back frames of 21 header bytes plus
// PAYLOAD_BYTES payload bytes, counted from reset with no resynchronization.
// Every input byte yields one output word with its offset and payload flag;
// the last byte of a frame carries tlast, the status (bad preamble before
// bad sum) and the little-endian header fields. One byte is taken per clock
// while the output does not stall; each byte passes the input register
// and the result register around the single-pass frame logic. Backpressure
// on the output side reaches s_axis_tready in the same cycle.
// ----------------------------------------------------------------------------
module fixed_frame_checker
    import ffc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // rx_byte[7:0]
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // data_byte[7:0], byte_offset[20:8], frame_status[22:21],
    // seq_number[54:23], stamp_seconds[86:55], stamp_micros[118:87],
    // payload_length[150:119], payload_type[166:151], zero[167]
    output logic [TDATA_W-1:0]    m_axis_tdata,
    output logic                  m_axis_tuser,   // in_payload
    output logic                  m_axis_tlast,   // frame_end
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0] r_expected_preamble;
    logic        w_reg_hit;

    logic        w_in_valid;
    logic [7:0]  w_in_byte;
    logic        w_advance;
    logic        w_fire;
    t_result     w_core_result;
    t_result     w_out_result;

    // register access
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[APB_ADDR_W-1] == REG_IDX_PREAMBLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_preamble <= PREAMBLE_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_expected_preamble <= pwdata[15:0];
        end
    end

    assign prdata = w_reg_hit ? {16'd0, r_expected_preamble} : 32'd0;

    // input register
    ffc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_byte    (s_axis_tdata),
        .i_advance (w_advance),
        .o_ready   (s_axis_tready),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    assign w_fire = w_in_valid && w_advance;

    // frame state and result forming
    ffc_frame_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fire              (w_fire),
        .i_byte              (w_in_byte),
        .i_expected_preamble (r_expected_preamble),
        .o_result            (w_core_result)
    );

    // result register
    ffc_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_in_valid),
        .i_result  (w_core_result),
        .i_ready   (m_axis_tready),
        .o_advance (w_advance),
        .o_valid   (m_axis_tvalid),
        .o_result  (w_out_result)
    );

    // output word packing
    assign m_axis_tdata = {1'b0,
                           w_out_result.payload_type,
                           w_out_result.payload_length,
                           w_out_result.stamp_micros,
                           w_out_result.stamp_seconds,
                           w_out_result.seq_number,
                           w_out_result.frame_status,
                           w_out_result.byte_offset,
                           w_out_result.data_byte};
    assign m_axis_tuser = w_out_result.in_payload;
    assign m_axis_tlast = w_out_result.frame_end;

endmodule

[rtl/core/ffc_checker.sv]
// ----------------------------------------------------------------------------
// ffc_checker
// Port-level checks of the frame checker output stream, bound to the top.
// ----------------------------------------------------------------------------
module ffc_checker
    import ffc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               m_axis_tlast
);

    localparam logic [OFFSET_W-1:0] FRAME_LAST =
        OFFSET_W'(HEADER_BYTES + PAYLOAD_BYTES - 1);

    // tlast marks exactly the last offset of a frame
    a_last_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[20:8] == FRAME_LAST)))
        else $error("tlast does not match frame end offset");

    // payload flag follows the offset
    a_payload_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == (m_axis_tdata[20:8] >= OFFSET_W'(HEADER_BYTES))))
        else $error("payload flag does not match offset");

    // status and header fields stay zero off the frame end
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[TDATA_W-1:21] == '0))
        else $error("header fields nonzero outside frame end");

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output word changed while stalled");

endmodule

bind fixed_frame_checker ffc_checker #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_ffc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
